// ===== hw/rtl/ise_pkg.sv =====
// Shared types and codes for the integer stack engine.
// Holds action and error codes, the internal command format and size constants.
// No dependencies.
`default_nettype none

package ise_pkg;

  localparam int ISE_STACK_DEPTH = 64;
  localparam int ISE_QUEUE_DEPTH = 2;
  localparam int ISE_DATA_W      = 32;

  // Action codes on the input channel
  localparam logic [2:0] ACT_PUSH = 3'd0;
  localparam logic [2:0] ACT_PALL = 3'd1;
  localparam logic [2:0] ACT_POP  = 3'd2;
  localparam logic [2:0] ACT_PINT = 3'd3;
  localparam logic [2:0] ACT_ADD  = 3'd4;

  // Error codes on the result channel
  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_FULL       = 3'd1;
  localparam logic [2:0] ERR_POP_EMPTY  = 3'd2;
  localparam logic [2:0] ERR_PINT_EMPTY = 3'd3;
  localparam logic [2:0] ERR_ADD_SHORT  = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_PALL,
    OP_POP,
    OP_PINT,
    OP_ADD,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                          op;
    logic signed [ISE_DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ise_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read data holds until the next read enable. No dependencies.
`default_nettype none

module ise_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ise_front.sv =====
// Front end: accepts requests, decodes the action into an internal command.
// Holds one decoded command until the queue takes it. Uses ise_pkg.
`default_nettype none

module ise_front
  import ise_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [2:0]                   in_action,
  input  wire  signed [ISE_DATA_W-1:0] in_push_value,
  output cmd_slot_t                    cmd_o,
  input  wire                          cmd_ready
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  op_t  op_dec;

  always_comb begin
    unique case (in_action)
      ACT_PUSH: op_dec = OP_PUSH;
      ACT_PALL: op_dec = OP_PALL;
      ACT_POP:  op_dec = OP_POP;
      ACT_PINT: op_dec = OP_PINT;
      ACT_ADD:  op_dec = OP_ADD;
      default:  op_dec = OP_NOP;
    endcase
  end

  assign in_ready = !valid_r || cmd_ready;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (in_valid && in_ready) begin
      valid_nxt     = 1'b1;
      cmd_nxt.op    = op_dec;
      cmd_nxt.value = in_push_value;
    end else if (cmd_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd_o.valid = valid_r;
  assign cmd_o.cmd   = cmd_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ise_queue.sv =====
// Short command queue between front end and back end.
// Circular buffer of decoded commands. Uses ise_pkg.
`default_nettype none

module ise_queue
  import ise_pkg::*;
#(
  parameter int DEPTH = ISE_QUEUE_DEPTH
) (
  input  wire       clk,
  input  wire       rst_n,
  input  cmd_slot_t push_i,
  output logic      push_ready,
  output cmd_slot_t head_o,
  input  wire       pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign do_push    = push_i.valid && push_ready;
  assign do_pop     = pop && (cnt_r != '0);

  always_comb begin
    wptr_nxt = do_push ? bump(wptr_r) : wptr_r;
    rptr_nxt = do_pop ? bump(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wptr_r] <= push_i.cmd;
    end
  end

  assign head_o.valid = (cnt_r != '0);
  assign head_o.cmd   = slot_r[rptr_r];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CW'(DEPTH)) && !pop |=> cnt_r == CW'(DEPTH))
    else $error("queue lost an entry while full");
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !head_o.valid)
    else $error("queue shows a head while empty");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ise_back.sv =====
// Back end: executes commands against the stack memory, drives the result register.
// Sequencer over one ise_ram instance. Uses ise_pkg.
`default_nettype none

module ise_back
  import ise_pkg::*;
#(
  parameter int STACK_DEPTH = ISE_STACK_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  cmd_slot_t                    head_i,
  output logic                         pop,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [ISE_DATA_W-1:0] out_value,
  output logic                         out_has_value,
  output logic [2:0]                   out_error,
  output logic                         out_last
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PINT = 5'b00010,
    S_ADD1 = 5'b00100,
    S_ADD2 = 5'b01000,
    S_PALL = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt, cnt_m1, cnt_m2;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [ISE_DATA_W-1:0]   opa_r, opa_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ISE_DATA_W-1:0]   out_value_r;
  logic                    out_has_r, out_last_r;
  logic [2:0]              out_error_r;

  logic                    out_free, emit;
  logic [ISE_DATA_W-1:0]   e_value;
  logic                    e_has, e_last;
  logic [2:0]              e_error;

  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic [ISE_DATA_W-1:0]   wdata, rdata;
  logic                    full, empty, short;

  ise_ram #(
    .WIDTH (ISE_DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m2   = cnt_r - CW'(2);
  assign full     = (cnt_r == CW'(STACK_DEPTH));
  assign empty    = (cnt_r == '0);
  assign short    = (cnt_r < CW'(2));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    opa_nxt   = opa_r;
    pop       = 1'b0;
    re        = 1'b0;
    raddr     = cnt_m1[AW-1:0];
    we        = 1'b0;
    waddr     = cnt_r[AW-1:0];
    wdata     = head_i.cmd.value;
    emit      = 1'b0;
    e_value   = '0;
    e_has     = 1'b0;
    e_error   = ERR_OK;
    e_last    = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (head_i.valid && out_free) begin
          pop = 1'b1;
          unique case (head_i.cmd.op)
            OP_PUSH: begin
              emit = 1'b1;
              if (full) begin
                e_error = ERR_FULL;
              end else begin
                we      = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            OP_POP: begin
              emit = 1'b1;
              if (empty) begin
                e_error = ERR_POP_EMPTY;
              end else begin
                cnt_nxt = cnt_m1;
              end
            end
            OP_PINT: begin
              if (empty) begin
                emit    = 1'b1;
                e_error = ERR_PINT_EMPTY;
              end else begin
                re        = 1'b1;
                state_nxt = S_PINT;
              end
            end
            OP_ADD: begin
              if (short) begin
                emit    = 1'b1;
                e_error = ERR_ADD_SHORT;
              end else begin
                re        = 1'b1;
                state_nxt = S_ADD1;
              end
            end
            OP_PALL: begin
              if (empty) begin
                emit = 1'b1;
              end else begin
                re        = 1'b1;
                idx_nxt   = cnt_m1[AW-1:0];
                state_nxt = S_PALL;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_PINT: begin
        if (out_free) begin
          emit      = 1'b1;
          e_value   = rdata;
          e_has     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ADD1: begin
        // top is in rdata; fetch the one below it
        opa_nxt   = rdata;
        re        = 1'b1;
        raddr     = cnt_m2[AW-1:0];
        state_nxt = S_ADD2;
      end
      S_ADD2: begin
        if (out_free) begin
          we        = 1'b1;
          waddr     = cnt_m2[AW-1:0];
          wdata     = rdata + opa_r;
          cnt_nxt   = cnt_m1;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PALL: begin
        // walk from top to bottom, one entry per taken result
        if (out_free) begin
          emit    = 1'b1;
          e_value = rdata;
          e_has   = 1'b1;
          e_last  = (idx_r == '0);
          if (idx_r != '0) begin
            re      = 1'b1;
            raddr   = idx_r - AW'(1);
            idx_nxt = idx_r - AW'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r <= idx_nxt;
    opa_r <= opa_nxt;
    if (emit) begin
      out_value_r <= e_value;
      out_has_r   <= e_has;
      out_error_r <= e_error;
      out_last_r  <= e_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_has_value = out_has_r;
  assign out_error     = out_error_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CW'(1)) || (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("stack count moved by more than one");
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PALL) || (state_r == S_PINT) |-> cnt_r != '0)
    else $error("stack read issued on an empty stack");
  a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_error_r != ERR_OK) |-> !out_has_r && out_last_r)
    else $error("error result carries a value or is not last");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/integer_stack_engine.sv =====
// Integer stack engine: bounded LIFO of signed 32-bit values driven by actions.
//
// Input channel (in_valid/in_ready): one request per action with in_action and
// in_push_value. Result channel (out_valid/out_ready): value, has_value, error
// and last. Each request gives one result, except print all on a non-empty
// stack, which gives one result per entry from top to bottom, last on the final.
// Requests pass a decode register and a two-entry command queue before the
// executing sequencer, so the input side keeps flowing while results stall.
// The sequencer takes one command at a time from the queue and starts no new one
// until the current one is done. The stack memory has a single read port:
// print top reads the top entry, then emits it; add reads the top entry, then
// the one below, then writes their sum; print all reads and emits each entry
// in turn, top to bottom. Push, pop and unused actions need no read.
// Reset (rst_n low, synchronous) empties the stack and drops queued requests
// and any pending result; memory contents are not cleared. When out_ready is
// low the result register holds and the sequencer waits; the queue then fills
// and in_ready falls.
// Depends on ise_pkg, ise_front, ise_queue, ise_back and ise_ram.
`default_nettype none

module integer_stack_engine
  import ise_pkg::*;
#(
  parameter int STACK_DEPTH = ISE_STACK_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [2:0]                   in_action,
  input  wire  signed [ISE_DATA_W-1:0] in_push_value,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [ISE_DATA_W-1:0] out_value,
  output logic                         out_has_value,
  output logic [2:0]                   out_error,
  output logic                         out_last
);

  cmd_slot_t front_cmd, queue_head;
  logic      queue_ready, queue_pop;

  ise_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_push_value (in_push_value),
    .cmd_o         (front_cmd),
    .cmd_ready     (queue_ready)
  );

  ise_queue #(
    .DEPTH (ISE_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (front_cmd),
    .push_ready (queue_ready),
    .head_o     (queue_head),
    .pop        (queue_pop)
  );

  ise_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_i        (queue_head),
    .pop           (queue_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_has_value (out_has_value),
    .out_error     (out_error),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire
